FILE: hdl/rca_pkg.sv
`timescale 1ns / 1ps
package rca_pkg;

  localparam int COV_DEPTH  = 65536;
  localparam int ADDR_W     = 16;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int POS_W      = 20;
  localparam int ORD_W      = 64;
  localparam int MOD_W      = 7;
  localparam int DIV_CNT_W  = 6;

  localparam logic [1:0] CMD_SINGLE = 2'd0;
  localparam logic [1:0] CMD_PAIR   = 2'd1;
  localparam logic [1:0] CMD_POINT  = 2'd2;
  localparam logic [1:0] CMD_REGION = 2'd3;

  localparam logic [1:0] STAT_COUNTED  = 2'd0;
  localparam logic [1:0] STAT_UNSEL    = 2'd1;
  localparam logic [1:0] STAT_FILTERED = 2'd2;
  localparam logic [1:0] STAT_QUERY    = 2'd3;

  localparam logic [2:0] REG_MODULUS  = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_CLONE    = 3'd2;
  localparam logic [2:0] REG_CHROM    = 3'd3;
  localparam logic [2:0] REG_SPAN     = 3'd4;

  localparam logic [11:0] PAIR_SPAN_RESET = 12'd800;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_DECIDE, ST_RRD, ST_RWR,
    ST_QSET, ST_PRD, ST_PWAIT, ST_SRD, ST_SACC, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    RES_COUNTED, RES_UNSEL, RES_FILT, RES_POINT, RES_REGION
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     div_step;
    logic     rec_starts;
    logic     range_init;
    logic     mem_rd;
    logic     mem_wr;
    logic     p_inc;
    logic     sum_clr;
    logic     sum_acc;
    logic     res_load;
    res_sel_t res_sel;
    logic     clr_we;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       div_last;
    logic       selected;
    logic       drop;
    logic       in_range;
    logic       clr_last;
  } dp_status_t;

endpackage

FILE: hdl/rca_ctrl.sv
`timescale 1ns / 1ps
module rca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  rca_pkg::dp_status_t   st,
  output rca_pkg::ctrl_cmd_t    cmd
);

  rca_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != rca_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rca_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rca_pkg::ST_CLEAR: if (st.clr_last) state_next = rca_pkg::ST_IDLE;
      rca_pkg::ST_IDLE: begin
        if (in_valid) state_next = rca_pkg::ST_DIV;
      end
      rca_pkg::ST_DIV: begin
        // queries skip selection entirely
        if (st.cmd == rca_pkg::CMD_POINT || st.cmd == rca_pkg::CMD_REGION)
          state_next = rca_pkg::ST_QSET;
        else if (st.div_last) state_next = rca_pkg::ST_DECIDE;
      end
      rca_pkg::ST_DECIDE: begin
        if (!st.selected || st.drop) state_next = rca_pkg::ST_FIN;
        else state_next = rca_pkg::ST_RRD;
      end
      rca_pkg::ST_RRD: state_next = st.in_range ? rca_pkg::ST_RWR : rca_pkg::ST_FIN;
      rca_pkg::ST_RWR: state_next = rca_pkg::ST_RRD;
      rca_pkg::ST_QSET: begin
        if (st.cmd == rca_pkg::CMD_POINT) state_next = rca_pkg::ST_PRD;
        else state_next = rca_pkg::ST_SRD;
      end
      rca_pkg::ST_PRD:   state_next = rca_pkg::ST_PWAIT;
      rca_pkg::ST_PWAIT: state_next = rca_pkg::ST_FIN;
      rca_pkg::ST_SRD: state_next = st.in_range ? rca_pkg::ST_SACC : rca_pkg::ST_FIN;
      rca_pkg::ST_SACC: state_next = rca_pkg::ST_SRD;
      rca_pkg::ST_FIN: if (out_free) state_next = rca_pkg::ST_IDLE;
      default: state_next = rca_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = rca_pkg::RES_COUNTED;
    case (state)
      rca_pkg::ST_CLEAR: cmd.clr_we = 1'b1;
      rca_pkg::ST_IDLE:  cmd.load_in = in_valid;
      rca_pkg::ST_DIV:   cmd.div_step = 1'b1;
      rca_pkg::ST_DECIDE: begin
        if (!st.selected) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rca_pkg::RES_UNSEL;
        end else begin
          cmd.rec_starts = 1'b1;
          if (st.drop) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = rca_pkg::RES_FILT;
          end else begin
            cmd.range_init = 1'b1;
          end
        end
      end
      rca_pkg::ST_RRD: begin
        if (st.in_range) cmd.mem_rd = 1'b1;
        else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rca_pkg::RES_COUNTED;
        end
      end
      rca_pkg::ST_RWR: begin
        cmd.mem_wr = 1'b1;
        cmd.p_inc  = 1'b1;
      end
      rca_pkg::ST_QSET: begin
        cmd.range_init = 1'b1;
        cmd.sum_clr    = 1'b1;
      end
      rca_pkg::ST_PRD: cmd.mem_rd = 1'b1;
      rca_pkg::ST_PWAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = rca_pkg::RES_POINT;
      end
      rca_pkg::ST_SRD: begin
        if (st.in_range) cmd.mem_rd = 1'b1;
        else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = rca_pkg::RES_REGION;
        end
      end
      rca_pkg::ST_SACC: begin
        cmd.sum_acc = 1'b1;
        cmd.p_inc   = 1'b1;
      end
      rca_pkg::ST_FIN: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/rca_dp.sv
`timescale 1ns / 1ps
module rca_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic [1:0]         cmd,
  input  logic [63:0]        ordinal,
  input  logic [19:0]        first_pos,
  input  logic signed [15:0] mate_delta,
  input  logic               first_rev,
  input  logic               mate_rev,
  input  logic [9:0]         first_len,
  input  logic [9:0]         mate_len,
  input  logic [19:0]        query_end,
  output logic [1:0]         status,
  output logic [47:0]        value,
  output logic [16:0]        span,
  input  rca_pkg::ctrl_cmd_t ctl,
  output rca_pkg::dp_status_t st
);

  // configuration
  logic [6:0]  modulus;
  logic [63:0] select_mask;
  logic        clone_filter;
  logic [15:0] chrom_len;
  logic [11:0] max_pair_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= '0;
      select_mask   <= '0;
      clone_filter  <= 1'b0;
      chrom_len     <= '0;
      max_pair_span <= rca_pkg::PAIR_SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rca_pkg::REG_MODULUS: modulus       <= cfg_data[6:0];
        rca_pkg::REG_MASK:    select_mask   <= cfg_data;
        rca_pkg::REG_CLONE:   clone_filter  <= cfg_data[0];
        rca_pkg::REG_CHROM:   chrom_len     <= cfg_data[15:0];
        rca_pkg::REG_SPAN:    max_pair_span <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // latched word
  logic [1:0]         c_cmd;
  logic [19:0]        p1, qend;
  logic signed [15:0] delta;
  logic               rev1, rev2;
  logic [9:0]         len1, len2;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      c_cmd <= cmd;
      p1    <= first_pos;
      delta <= mate_delta;
      rev1  <= first_rev;
      rev2  <= mate_rev;
      len1  <= first_len;
      len2  <= mate_len;
      qend  <= query_end;
    end
  end

  // restoring remainder, one ordinal bit per cycle
  logic [63:0] ord_sh;
  logic [6:0]  rem;
  logic [5:0]  div_cnt;
  logic [7:0]  rem_sh;

  assign rem_sh = {rem, ord_sh[63]};

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      ord_sh  <= ordinal;
      rem     <= '0;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      ord_sh  <= {ord_sh[62:0], 1'b0};
      div_cnt <= div_cnt + 6'd1;
      if (rem_sh >= {1'b0, modulus}) rem <= 7'(rem_sh - {1'b0, modulus});
      else rem <= rem_sh[6:0];
    end
  end

  // start checks in 22-bit signed arithmetic
  logic signed [21:0] s1, s2, e1, e2, emax, lim_rd, chrom_s;
  logic [16:0]        mag;
  logic [19:0]        p2w, last_a, last_b;
  logic               ok1, ok2, drop_single, drop_pair;

  assign s1      = $signed({2'b00, p1});
  assign s2      = s1 + 22'(delta);
  assign p2w     = s2[19:0];
  assign chrom_s = $signed({6'd0, chrom_len});
  assign mag     = delta[15] ? 17'(-$signed({delta[15], delta})) : {1'b0, delta};
  assign ok1     = (s1 > 0) && (s1 <= chrom_s);
  assign ok2     = (s2 > 0) && (s2 <= chrom_s);
  assign e1      = s1 + $signed({12'd0, len1});
  assign e2      = s2 + $signed({12'd0, len2});
  assign emax    = (c_cmd == rca_pkg::CMD_PAIR && e2 > e1) ? e2 : e1;
  assign lim_rd  = ((emax - 22'sd1) < chrom_s) ? (emax - 22'sd1) : chrom_s;

  assign drop_single = !ok1 || (clone_filter && p1 == last_a);
  assign drop_pair   = (mag >= {5'd0, max_pair_span}) || (rev1 == rev2) || !ok1 || !ok2 ||
                       (clone_filter && p1 == last_a && p2w == last_b) ||
                       (clone_filter && p1 == last_b && p2w == last_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_a <= '0;
      last_b <= '0;
    end else if (ctl.rec_starts) begin
      last_a <= p1;
      if (c_cmd == rca_pkg::CMD_PAIR) last_b <= p2w;
    end
  end

  // address walk
  logic [20:0] p, lim;
  logic [19:0] qhi;
  logic        qnonempty;

  assign qhi       = (qend > 20'd65535) ? 20'd65535 : qend;
  assign qnonempty = (p1 <= qhi);

  always_ff @(posedge clk) begin
    if (ctl.range_init) begin
      case (c_cmd)
        rca_pkg::CMD_SINGLE: begin
          p   <= {1'b0, p1};
          lim <= lim_rd[20:0];
        end
        rca_pkg::CMD_PAIR: begin
          p   <= (s2 < s1) ? s2[20:0] : s1[20:0];
          lim <= lim_rd[20:0];
        end
        default: begin
          p   <= {1'b0, p1};
          lim <= {1'b0, qhi};
        end
      endcase
    end else if (ctl.p_inc) begin
      p <= p + 21'd1;
    end
  end

  // coverage store with clearing pass
  logic [31:0] mem [rca_pkg::COV_DEPTH];
  logic [31:0] rdata;
  logic [15:0] clr_cnt;
  logic        mem_we;
  logic [15:0] waddr;
  logic [31:0] wdata;

  assign mem_we = ctl.clr_we || ctl.mem_wr;
  assign waddr  = ctl.clr_we ? clr_cnt : p[15:0];
  assign wdata  = ctl.clr_we ? 32'd0 : ((&rdata) ? rdata : rdata + 32'd1);

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (ctl.clr_we) clr_cnt <= clr_cnt + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (ctl.mem_rd) rdata <= mem[p[15:0]];
  end

  // region sum
  logic [47:0] sum;
  logic [48:0] sum_add;

  assign sum_add = {1'b0, sum} + {17'd0, rdata};

  always_ff @(posedge clk) begin
    if (ctl.sum_clr) sum <= '0;
    else if (ctl.sum_acc) sum <= sum_add[48] ? {48{1'b1}} : sum_add[47:0];
  end

  // result and output registers
  logic [1:0]  res_status;
  logic [47:0] res_value;
  logic [16:0] res_span;

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      case (ctl.res_sel)
        rca_pkg::RES_UNSEL: begin
          res_status <= rca_pkg::STAT_UNSEL;
          res_value  <= '0;
          res_span   <= '0;
        end
        rca_pkg::RES_FILT: begin
          res_status <= rca_pkg::STAT_FILTERED;
          res_value  <= '0;
          res_span   <= '0;
        end
        rca_pkg::RES_POINT: begin
          res_status <= rca_pkg::STAT_QUERY;
          res_value  <= (p1[19:16] == 4'd0) ? {16'd0, rdata} : 48'd0;
          res_span   <= 17'd1;
        end
        rca_pkg::RES_REGION: begin
          res_status <= rca_pkg::STAT_QUERY;
          res_value  <= qnonempty ? sum : 48'd0;
          res_span   <= qnonempty ? 17'({1'b0, qhi} - {1'b0, p1} + 21'd1) : 17'd0;
        end
        default: begin
          res_status <= rca_pkg::STAT_COUNTED;
          res_value  <= '0;
          res_span   <= '0;
        end
      endcase
    end
    if (ctl.out_load) begin
      status <= res_status;
      value  <= res_value;
      span   <= res_span;
    end
  end

  assign st.cmd      = c_cmd;
  assign st.div_last = (div_cnt == 6'd63);
  assign st.selected = (modulus < 7'd2) || (!rem[6] && select_mask[rem[5:0]]);
  assign st.drop     = (c_cmd == rca_pkg::CMD_PAIR) ? drop_pair : drop_single;
  assign st.in_range = (p <= lim);
  assign st.clr_last = (clr_cnt == 16'hFFFF);

endmodule

FILE: hdl/read_coverage_accumulator.sv
`timescale 1ns / 1ps
// Reads: the ordinal remainder is formed one bit at a time, then a decision state selects
// or drops the read, then each covered position takes a read-modify-write on the store.
// Point queries read one position; region sums read and add each position in turn.
// One word at a time; a finished result waits in the output register.
// Reset: synchronous; a clearing pass zeroes the 65536-entry store, during which no word is
// accepted (configuration writes are taken).
module read_coverage_accumulator (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [63:0]        ordinal,
  input  logic [19:0]        first_pos,
  input  logic signed [15:0] mate_delta,
  input  logic               first_rev,
  input  logic               mate_rev,
  input  logic [9:0]         first_len,
  input  logic [9:0]         mate_len,
  input  logic [19:0]        query_end,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [47:0]        value,
  output logic [16:0]        span
);

  rca_pkg::ctrl_cmd_t  ctl;
  rca_pkg::dp_status_t st;

  // sequencer: clearing pass, selection, range walk, result hand-off
  rca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (ctl)
  );

  // datapath: config, remainder unit, checks, coverage store, sum, output word
  rca_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .ordinal    (ordinal),
    .first_pos  (first_pos),
    .mate_delta (mate_delta),
    .first_rev  (first_rev),
    .mate_rev   (mate_rev),
    .first_len  (first_len),
    .mate_len   (mate_len),
    .query_end  (query_end),
    .status     (status),
    .value      (value),
    .span       (span),
    .ctl        (ctl),
    .st         (st)
  );

endmodule

FILE: tb/read_coverage_accumulator_tb.sv
`timescale 1ns / 1ps
module read_coverage_accumulator_tb;

  typedef struct {
    logic [1:0]         cmd;
    logic [63:0]        ord;
    logic [19:0]        first_pos;
    logic signed [15:0] mate_delta;
    logic               first_rev;
    logic               mate_rev;
    logic [9:0]         first_len;
    logic [9:0]         mate_len;
    logic [19:0]        query_end;
  } word_t;

  typedef struct {
    logic [1:0]  status;
    logic [47:0] value;
    logic [16:0] span;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = '0;
  logic [63:0]        ordinal = '0;
  logic [19:0]        first_pos = '0;
  logic signed [15:0] mate_delta = '0;
  logic               first_rev = 1'b0;
  logic               mate_rev = 1'b0;
  logic [9:0]         first_len = '0;
  logic [9:0]         mate_len = '0;
  logic [19:0]        query_end = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [47:0]        value;
  logic [16:0]        span;

  read_coverage_accumulator i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .ordinal(ordinal), .first_pos(first_pos), .mate_delta(mate_delta),
    .first_rev(first_rev), .mate_rev(mate_rev), .first_len(first_len),
    .mate_len(mate_len), .query_end(query_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .value(value), .span(span)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: registers, per-position depth and the clone history.
  logic [6:0]  modulus_r;
  logic [63:0] mask_r;
  logic        clone_r;
  logic [15:0] chrom_r;
  logic [11:0] pair_span_r;
  logic [31:0] depth_model [0:rca_pkg::COV_DEPTH-1];
  logic [19:0] prev_start_a;
  logic [19:0] prev_start_b;

  word_t   pending_words[$];
  result_t expected_results[$];
  word_t   cur_word;
  result_t got_result;
  result_t exp_result;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          words_sent = 0;
  int          status_seen [4];
  logic [19:0] gen_a;
  logic [19:0] gen_b;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic bit read_selected(logic [63:0] ord);
    logic [63:0] rem;
    if (modulus_r < 2) return 1'b1;
    rem = ord % modulus_r;
    if (rem >= 64) return 1'b0;
    return mask_r[rem[5:0]];
  endfunction

  function automatic bit start_valid(longint s);
    return s > 0 && s <= longint'(chrom_r);
  endfunction

  // Add one over [lo, hi); drop positions past the chromosome or the store.
  function automatic void add_depth(longint lo, longint hi);
    for (longint p = lo; p < hi; p++) begin
      if (p < 0 || p > longint'(chrom_r) || p >= rca_pkg::COV_DEPTH) continue;
      if (depth_model[p] != 32'hFFFF_FFFF) depth_model[p] = depth_model[p] + 32'd1;
    end
  endfunction

  function automatic result_t coverage_result(word_t w);
    result_t     r;
    longint      s1, s2, mag, e1, e2, hi;
    logic [19:0] p2w;
    logic [63:0] sum;
    bit          drop;
    r.status = rca_pkg::STAT_COUNTED;
    r.value  = '0;
    r.span   = '0;
    s1 = longint'(w.first_pos);
    case (w.cmd)
      rca_pkg::CMD_SINGLE: begin
        if (!read_selected(w.ord)) begin
          r.status = rca_pkg::STAT_UNSEL;
        end else begin
          drop = !start_valid(s1) || (clone_r && w.first_pos == prev_start_a);
          prev_start_a = w.first_pos;
          if (drop) r.status = rca_pkg::STAT_FILTERED;
          else add_depth(s1, s1 + longint'(w.first_len));
        end
      end
      rca_pkg::CMD_PAIR: begin
        if (!read_selected(w.ord)) begin
          r.status = rca_pkg::STAT_UNSEL;
        end else begin
          s2   = s1 + longint'(w.mate_delta);
          p2w  = s2[19:0];
          mag  = s2 > s1 ? s2 - s1 : s1 - s2;
          drop = mag >= longint'(pair_span_r) || w.first_rev == w.mate_rev ||
                 !start_valid(s1) || !start_valid(s2);
          if (clone_r && w.first_pos == prev_start_a && p2w == prev_start_b) drop = 1'b1;
          if (clone_r && w.first_pos == prev_start_b && p2w == prev_start_a) drop = 1'b1;
          prev_start_a = w.first_pos;
          prev_start_b = p2w;
          if (drop) begin
            r.status = rca_pkg::STAT_FILTERED;
          end else begin
            e1 = s1 + longint'(w.first_len);
            e2 = s2 + longint'(w.mate_len);
            add_depth(s1 < s2 ? s1 : s2, e1 > e2 ? e1 : e2);
          end
        end
      end
      rca_pkg::CMD_POINT: begin
        r.status = rca_pkg::STAT_QUERY;
        r.span   = 17'd1;
        if (s1 < rca_pkg::COV_DEPTH) r.value = 48'(depth_model[s1]);
      end
      default: begin
        r.status = rca_pkg::STAT_QUERY;
        hi = longint'(w.query_end);
        if (hi > rca_pkg::COV_DEPTH - 1) hi = longint'(rca_pkg::COV_DEPTH - 1);
        if (s1 <= hi) begin
          sum = '0;
          for (longint p = s1; p <= hi; p++) begin
            sum = sum + 64'(depth_model[p]);
            if (sum > 64'hFFFF_FFFF_FFFF) sum = 64'hFFFF_FFFF_FFFF;
          end
          r.value = sum[47:0];
          r.span  = 17'(hi - s1 + 1);
        end
      end
    endcase
    return r;
  endfunction

  // Driver: predict on acceptance, then present the next word or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(coverage_result(cur_word));
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() == 0 || $urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          cur_word = pending_words.pop_front();
          cmd        <= cur_word.cmd;
          ordinal    <= cur_word.ord;
          first_pos  <= cur_word.first_pos;
          mate_delta <= cur_word.mate_delta;
          first_rev  <= cur_word.first_rev;
          mate_rev   <= cur_word.mate_rev;
          first_len  <= cur_word.first_len;
          mate_len   <= cur_word.mate_len;
          query_end  <= cur_word.query_end;
          in_valid   <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_result.status = status;
        got_result.value  = value;
        got_result.span   = span;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", 64'(status), 64'(0));
        end else begin
          exp_result = expected_results.pop_front();
          if (got_result.status != exp_result.status)
            report_mismatch("status", 64'(got_result.status), 64'(exp_result.status));
          if (got_result.value != exp_result.value)
            report_mismatch("value", 64'(got_result.value), 64'(exp_result.value));
          if (got_result.span != exp_result.span)
            report_mismatch("span", 64'(got_result.span), 64'(exp_result.span));
          status_seen[exp_result.status]++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Write one register and mirror it; called with no words in flight.
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rca_pkg::REG_MODULUS: modulus_r   = data[6:0];
      rca_pkg::REG_MASK:    mask_r      = data;
      rca_pkg::REG_CLONE:   clone_r     = data[0];
      rca_pkg::REG_CHROM:   chrom_r     = data[15:0];
      default:              pair_span_r = data[11:0];
    endcase
  endtask

  task automatic set_regs(logic [6:0] m, logic [63:0] k, logic c, logic [15:0] ch,
                          logic [11:0] sp);
    write_reg(rca_pkg::REG_MODULUS, 64'(m));
    write_reg(rca_pkg::REG_MASK, k);
    write_reg(rca_pkg::REG_CLONE, 64'(c));
    write_reg(rca_pkg::REG_CHROM, 64'(ch));
    write_reg(rca_pkg::REG_SPAN, 64'(sp));
  endtask

  // Hold new words until every prediction has come back.
  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_word(logic [1:0] c, logic [63:0] o, logic [19:0] p,
                           logic signed [15:0] d, logic r1, logic r2,
                           logic [9:0] l1, logic [9:0] l2, logic [19:0] q);
    word_t w;
    w.cmd = c; w.ord = o; w.first_pos = p; w.mate_delta = d;
    w.first_rev = r1; w.mate_rev = r2; w.first_len = l1; w.mate_len = l2;
    w.query_end = q;
    pending_words.push_back(w);
  endtask

  function automatic logic [19:0] pick_pos();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 20'd0;
    if (k == 1) return 20'(chrom_r);
    if (k == 2) return 20'(chrom_r) + 20'd1;
    if (k == 3) return 20'($urandom);
    return 20'($urandom_range(chrom_r > 1 ? chrom_r : 1, 1));
  endfunction

  // Mostly well-formed reads with random content; some noise and clones.
  task automatic push_random();
    word_t  w;
    int     k;
    longint mag;
    longint d;
    k = $urandom_range(99);
    w.ord        = {$urandom, $urandom};
    w.first_rev  = 1'($urandom);
    w.mate_rev   = 1'($urandom);
    w.first_len  = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(80));
    w.mate_len   = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(80));
    w.mate_delta = 16'($urandom);
    w.query_end  = 20'($urandom);
    w.first_pos  = pick_pos();
    if (k < 35) begin
      w.cmd = rca_pkg::CMD_SINGLE;
      if ($urandom_range(4) == 0) w.first_pos = gen_a;
      gen_a = w.first_pos;
    end else if (k < 75) begin
      w.cmd = rca_pkg::CMD_PAIR;
      if ($urandom_range(9) < 8) begin
        w.mate_rev = ~w.first_rev;
        mag = pair_span_r > 1 ? longint'($urandom_range(pair_span_r - 1)) : longint'(0);
        if (mag > 1500 && $urandom_range(3) != 0) mag = longint'($urandom_range(200));
        w.mate_delta = 16'($urandom_range(1) ? -mag : mag);
      end
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1)) begin
          w.first_pos = gen_a; d = longint'(gen_b) - longint'(gen_a);
        end else begin
          w.first_pos = gen_b; d = longint'(gen_a) - longint'(gen_b);
        end
        if (d > -32768 && d < 32768) w.mate_delta = 16'(d);
      end
      gen_a = w.first_pos;
      gen_b = 20'(longint'(w.first_pos) + longint'(w.mate_delta));
    end else if (k < 87) begin
      w.cmd = rca_pkg::CMD_POINT;
    end else begin
      w.cmd = rca_pkg::CMD_REGION;
      k = $urandom_range(19);
      if (k == 0) begin
        // far end high: start near or past the store end keeps it short
        w.first_pos = $urandom_range(1) ? 20'(65535 - $urandom_range(100))
                                        : 20'($urandom_range(20'hFFFFF, 65536));
      end else if (k == 1) begin
        w.query_end = w.first_pos - 20'($urandom_range(5));
      end else begin
        if (w.first_pos >= rca_pkg::COV_DEPTH) w.first_pos = 20'($urandom_range(chrom_r));
        w.query_end = w.first_pos + 20'($urandom_range(63));
      end
    end
    pending_words.push_back(w);
  endtask

  initial begin
    modulus_r = '0; mask_r = '0; clone_r = 1'b0; chrom_r = '0;
    pair_span_r = rca_pkg::PAIR_SPAN_RESET;
    prev_start_a = '0; prev_start_b = '0;
    gen_a = '0; gen_b = '0;
    foreach (depth_model[i]) depth_model[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset span of 800 kept, everything else set.
    write_reg(rca_pkg::REG_MODULUS, 64'd0);
    write_reg(rca_pkg::REG_MASK, '1);
    write_reg(rca_pkg::REG_CLONE, 64'd0);
    write_reg(rca_pkg::REG_CHROM, 64'd3000);
    push_word(rca_pkg::CMD_SINGLE, '1, 20'd1, 16'sd0, 1'b0, 1'b0, 10'd10, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_SINGLE, '0, 20'd5, 16'sd0, 1'b1, 1'b1, 10'd0, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_SINGLE, '0, 20'd0, 16'sd0, 1'b0, 1'b0, 10'd5, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_SINGLE, '0, 20'd2998, 16'sd0, 1'b0, 1'b0, 10'd9, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_SINGLE, '0, 20'd3001, 16'sd0, 1'b0, 1'b0, 10'd9, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_SINGLE, '0, 20'hFFFFF, 16'sd0, 1'b0, 1'b0, 10'd9, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_SINGLE, '0, 20'd40, 16'sd0, 1'b0, 1'b0, 10'd1023, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd100, 16'sd50, 1'b0, 1'b1, 10'd30, 10'd30, 20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd300, -16'sd40, 1'b1, 1'b0, 10'd20, 10'd90,
              20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd300, 16'sd40, 1'b1, 1'b1, 10'd20, 10'd20, 20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd900, 16'sd799, 1'b0, 1'b1, 10'd5, 10'd5, 20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd900, -16'sd800, 1'b0, 1'b1, 10'd5, 10'd5, 20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd10, -16'sd10, 1'b0, 1'b1, 10'd5, 10'd5, 20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd10, -16'sd32767, 1'b1, 1'b0, 10'd5, 10'd5,
              20'd0);
    push_word(rca_pkg::CMD_PAIR, 64'd7, 20'd10, 16'sd32767, 1'b1, 1'b0, 10'd1023, 10'd1023,
              20'd0);
    push_word(rca_pkg::CMD_POINT, '0, 20'd1, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_POINT, '0, 20'd0, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_POINT, '0, 20'd65535, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_POINT, '0, 20'd65536, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_POINT, '0, 20'hFFFFF, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd0);
    push_word(rca_pkg::CMD_REGION, '0, 20'd1, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd200);
    push_word(rca_pkg::CMD_REGION, '0, 20'd50, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'd49);
    push_word(rca_pkg::CMD_REGION, '0, 20'd0, 16'sd0, 1'b0, 1'b0, 10'd0, 10'd0, 20'hFFFFF);
    drain();

    // Random phases, each with its own register set and one of four idle and stall mixes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(7'd5, {$urandom, $urandom}, 1'b1, 16'd65535, 12'd4095);
        1: set_regs(7'd64, {$urandom, $urandom}, 1'b1, 16'd500, 12'd0);
        2: set_regs(7'd127, '1, 1'b0, 16'd1, 12'd1);
        3: set_regs(7'd1, 64'd0, 1'b0, 16'd0, 12'd300);
        4: set_regs(7'd3, 64'h5, 1'b1, 16'd20000, 12'd1000);
        default: set_regs(7'd0, '0, 1'b1, 16'd2000, 12'd800);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < 115; n++) begin
        push_random();
        // bursts: let the queue run dry now and then
        if ($urandom_range(29) == 0)
          while (pending_words.size() != 0) @(posedge clk);
      end
      drain();
    end

    $display("covered %0d words: %0d counted, %0d unselected, %0d filtered, %0d queries",
             words_sent, status_seen[rca_pkg::STAT_COUNTED], status_seen[rca_pkg::STAT_UNSEL],
             status_seen[rca_pkg::STAT_FILTERED], status_seen[rca_pkg::STAT_QUERY]);
    $display("register sets include modulus 0/1/127, chromosome 0/1/65535, span 0/4095");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Generous bound: clearing pass, a full-store sum, wide pairs, heavy stalls.
  initial begin
    #(64'd240_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
hdl/rca_pkg.sv
hdl/rca_ctrl.sv
hdl/rca_dp.sv
hdl/read_coverage_accumulator.sv
tb/read_coverage_accumulator_tb.sv
